// ===== hw/rtl/gkm_pkg.sv =====
// Shared types and constants for the grouped key mean aggregator.
package gkm_pkg;

  localparam int MAX_GROUPS  = 64;
  localparam int GRP_W       = 6;
  localparam int USED_W      = 7;
  localparam int CNT_W       = 13;
  localparam int MAX_ENTRIES = 4096;
  localparam int SUMD_W      = 28;
  localparam int SUMT_W      = 36;
  localparam int KEY_W       = 32;
  localparam int DIV_CNT_W   = 6;
  localparam logic [CNT_W-1:0] MIN_COUNT_RST = 13'd5;

  typedef struct packed {
    logic [31:0]        path_key;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [23:0]        hit_time;
    logic               last_entry;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         group_index;
    logic [31:0]        group_key;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] mean_z;
    logic [23:0]        mean_time;
    logic               group_overflow;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    logic signed [SUMD_W-1:0] sx;
    logic signed [SUMD_W-1:0] sy;
    logic signed [SUMD_W-1:0] sz;
    logic [SUMT_W-1:0]        st;
  } acc_t;

  localparam int ACC_W = $bits(acc_t);

  // status of the back end seen by the top level
  typedef struct packed {
    logic              draining;
    logic [USED_W-1:0] used;
  } back_stat_t;

endpackage

// ===== hw/rtl/gkm_if.sv =====
// Handshake channel interfaces: input items, results, configuration.
interface gkm_in_if import gkm_pkg::*; ;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gkm_out_if import gkm_pkg::*; ;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gkm_cfg_if import gkm_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gkm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/gkm_front.sv =====
// Front end: accepts input requests into a two-entry queue for the back end.
module gkm_front import gkm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gkm_in_if.sink     in_ch,
  output logic       q_vld,
  output in_item_t   q_item,
  input  logic       q_pop
);
  in_item_t   buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push   = in_ch.valid & in_ch.ready;
  assign q_vld  = (cnt_r != 2'd0);
  assign q_item = buf_r[rp_r];

  // payload storage
  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_ch.data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== hw/rtl/gkm_div.sv =====
// Restoring divider, one quotient bit per cycle: 36-bit dividend by 13-bit count.
module gkm_div import gkm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUMT_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [SUMT_W-1:0] quot
);
  logic [SUMT_W-1:0]    q_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [CNT_W:0]       shl;
  logic [CNT_W:0]       diff;
  logic                 fits;

  assign shl  = {rem_r, q_r[SUMT_W-1]};
  assign diff = shl - {1'b0, dvs_r};
  assign fits = (shl >= {1'b0, dvs_r});
  assign done = done_r;
  assign quot = q_r;

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[CNT_W-1:0] : shl[CNT_W-1:0];
      q_r   <= {q_r[SUMT_W-2:0], fits};
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(SUMT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/gkm_back.sv =====
// Back end: key search, accumulation, and the averaging drain after the last entry.
module gkm_back import gkm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] min_count,
  input  logic             q_vld,
  input  in_item_t         q_item,
  output logic             q_pop,
  gkm_out_if.source        out_ch,
  output back_stat_t       stat
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SRCH = 4'd1, S_CMP = 4'd2, S_MISS = 4'd3,
                         S_ACCW = 4'd4, S_FIN = 4'd5, S_DRD = 4'd6, S_DCHK = 4'd7,
                         S_DST = 4'd8, S_DIV = 4'd9, S_DEMIT = 4'd10, S_DNXT = 4'd11,
                         S_DEND = 4'd12;

  logic [3:0]        st_r;
  in_item_t          item_r;
  logic [GRP_W-1:0]  idx_r;
  logic [USED_W-1:0] used_r;
  logic              ovf_r;
  acc_t              acc_r;
  logic [KEY_W-1:0]  dkey_r;
  logic [1:0]        ph_r;
  logic [15:0]       mx_r, my_r, mz_r;
  logic              pend_vld_r;
  out_item_t         pend_r;
  logic              out_vld_r;
  out_item_t         out_r;

  logic              key_we, acc_we;
  logic [GRP_W-1:0]  key_waddr, key_raddr, acc_waddr;
  logic [KEY_W-1:0]  key_rdata;
  acc_t              acc_wdata, acc_rdata;
  logic [ACC_W-1:0]  acc_rbits;
  logic              div_start, div_done;
  logic [SUMT_W-1:0] div_dvd, div_q;
  logic [USED_W-1:0] idx_inc;
  logic              more;
  logic              out_free;
  logic              out_load;
  out_item_t         out_nxt;
  logic [SUMD_W-1:0] cur_sum;
  logic              cur_neg;
  logic [SUMD_W-1:0] cur_mag;
  logic [15:0]       mean16;
  out_item_t         new_res;

  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign more     = (idx_inc < used_r);
  assign out_free = !out_vld_r || out_ch.ready;
  assign acc_rdata = acc_t'(acc_rbits);

  gkm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_GROUPS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(item_r.path_key),
    .raddr(key_raddr), .rdata(key_rdata));

  gkm_ram #(.WIDTH(ACC_W), .DEPTH(MAX_GROUPS)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(idx_r), .rdata(acc_rbits));

  gkm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(acc_r.cnt), .done(div_done), .quot(div_q));

  // table addresses and write data
  always_comb begin
    key_raddr = (st_r == S_CMP) ? idx_inc[GRP_W-1:0] : idx_r;
    key_waddr = used_r[GRP_W-1:0];
    key_we    = (st_r == S_MISS) && (used_r < USED_W'(MAX_GROUPS));
    acc_we    = 1'b0;
    acc_waddr = idx_r;
    acc_wdata = acc_rdata;
    if (st_r == S_MISS) begin
      acc_we       = key_we;
      acc_waddr    = used_r[GRP_W-1:0];
      acc_wdata.cnt = CNT_W'(1);
      acc_wdata.sx = {{(SUMD_W-16){item_r.dir_x[15]}}, item_r.dir_x};
      acc_wdata.sy = {{(SUMD_W-16){item_r.dir_y[15]}}, item_r.dir_y};
      acc_wdata.sz = {{(SUMD_W-16){item_r.dir_z[15]}}, item_r.dir_z};
      acc_wdata.st = {{(SUMT_W-24){1'b0}}, item_r.hit_time};
    end else if (st_r == S_ACCW) begin
      acc_we        = (acc_rdata.cnt < CNT_W'(MAX_ENTRIES));
      acc_wdata.cnt = acc_rdata.cnt + 1'b1;
      acc_wdata.sx  = acc_rdata.sx + {{(SUMD_W-16){item_r.dir_x[15]}}, item_r.dir_x};
      acc_wdata.sy  = acc_rdata.sy + {{(SUMD_W-16){item_r.dir_y[15]}}, item_r.dir_y};
      acc_wdata.sz  = acc_rdata.sz + {{(SUMD_W-16){item_r.dir_z[15]}}, item_r.dir_z};
      acc_wdata.st  = acc_rdata.st + {{(SUMT_W-24){1'b0}}, item_r.hit_time};
    end
  end

  // divider operand: sum magnitude for the direction phases, time sum last
  always_comb begin
    case (ph_r)
      2'd0:    cur_sum = acc_r.sx;
      2'd1:    cur_sum = acc_r.sy;
      default: cur_sum = acc_r.sz;
    endcase
    cur_neg   = cur_sum[SUMD_W-1];
    cur_mag   = cur_neg ? (~cur_sum + 1'b1) : cur_sum;
    div_dvd   = (ph_r == 2'd3) ? acc_r.st : {{(SUMT_W-SUMD_W){1'b0}}, cur_mag};
    div_start = (st_r == S_DST);
    mean16    = cur_neg ? (~div_q[15:0] + 1'b1) : div_q[15:0];
  end

  // assembled result of the current group
  always_comb begin
    new_res.group_index    = idx_r;
    new_res.group_key      = dkey_r;
    new_res.mean_x         = mx_r;
    new_res.mean_y         = my_r;
    new_res.mean_z         = mz_r;
    new_res.mean_time      = div_q[23:0];
    new_res.group_overflow = ovf_r;
    new_res.last_result    = 1'b0;
  end

  // pending result moves to the output register; marked last at the end
  assign out_load = pend_vld_r && out_free && (st_r == S_DEMIT || st_r == S_DEND);
  always_comb begin
    out_nxt             = pend_r;
    out_nxt.last_result = (st_r == S_DEND);
  end

  assign q_pop        = (st_r == S_IDLE) && q_vld;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;
  assign stat.draining = (st_r >= S_DRD);
  assign stat.used     = used_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    if (st_r == S_DCHK) begin
      acc_r  <= acc_rdata;
      dkey_r <= key_rdata;
    end
    if (st_r == S_DIV && div_done) begin
      case (ph_r)
        2'd0:    mx_r <= mean16;
        2'd1:    my_r <= mean16;
        2'd2:    mz_r <= mean16;
        default: ;
      endcase
    end
    if (st_r == S_DEMIT && (!pend_vld_r || out_free)) pend_r <= new_res;
    if (out_load) out_r <= out_nxt;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      idx_r      <= '0;
      used_r     <= '0;
      ovf_r      <= 1'b0;
      ph_r       <= 2'd0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_load) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_vld) begin
          idx_r <= '0;
          st_r  <= (used_r == '0) ? S_MISS : S_SRCH;
        end
        S_SRCH: st_r <= S_CMP;
        S_CMP: begin
          if (key_rdata == item_r.path_key) st_r <= S_ACCW;
          else if (more) idx_r <= idx_inc[GRP_W-1:0];
          else st_r <= S_MISS;
        end
        S_MISS: begin
          if (key_we) used_r <= used_r + 1'b1;
          else ovf_r <= 1'b1;
          st_r <= S_FIN;
        end
        S_ACCW: st_r <= S_FIN;
        S_FIN: begin
          idx_r <= '0;
          st_r  <= item_r.last_entry ? S_DRD : S_IDLE;
        end
        S_DRD: st_r <= S_DCHK;
        S_DCHK: begin
          ph_r <= 2'd0;
          if (acc_rdata.cnt != '0 && acc_rdata.cnt >= min_count) st_r <= S_DST;
          else st_r <= S_DNXT;
        end
        S_DST: st_r <= S_DIV;
        S_DIV: if (div_done) begin
          ph_r <= ph_r + 1'b1;
          st_r <= (ph_r == 2'd3) ? S_DEMIT : S_DST;
        end
        S_DEMIT: begin
          if (!pend_vld_r) begin
            pend_vld_r <= 1'b1;
            st_r       <= S_DNXT;
          end else if (out_free) begin
            st_r <= S_DNXT;
          end
        end
        S_DNXT: begin
          if (more) begin
            idx_r <= idx_inc[GRP_W-1:0];
            st_r  <= S_DRD;
          end else begin
            st_r <= S_DEND;
          end
        end
        S_DEND: begin
          if (!pend_vld_r || out_free) begin
            pend_vld_r <= 1'b0;
            used_r     <= '0;
            ovf_r      <= 1'b0;
            st_r       <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/grouped_key_mean_aggregator.sv =====
// Top level of the grouped key mean aggregator.
// Usage:
//   in_ch  : entry requests (key, direction, time, last flag), valid/ready.
//   out_ch : one result per qualifying group, valid/ready, sent after the
//            entry marked last, in first-seen group order; last_result is set
//            on the final one. A node with no qualifying group sends nothing.
//   cfg_ch : writes min_count; ready is always high. Write only when idle.
// Timing: an entry passes through a two-entry front queue, then the back
//   end scans the key table one stored key per cycle (registered RAM read).
//   After the last entry a qualifying group takes four divider runs on the
//   single shared 36-step divider; a group that does not qualify skips the
//   divider.
// Reset: synchronous, active low; clears the group count, overflow flag,
//   queue and output register; min_count returns to 5. Table RAMs are not
//   cleared, the group count bounds every read.
// Stall: a held result plus one waiting behind it stall the drain; entries
//   keep queueing until the front queue is full, then in_ch.ready drops.
module grouped_key_mean_aggregator import gkm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  gkm_in_if.sink    in_ch,
  gkm_out_if.source out_ch,
  gkm_cfg_if.sink   cfg_ch
);
  logic [CNT_W-1:0] min_count_r;
  logic             q_vld, q_pop;
  in_item_t         q_item;
  back_stat_t       stat;

  // configuration register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) min_count_r <= MIN_COUNT_RST;
    else if (cfg_ch.valid) min_count_r <= cfg_ch.data;
  end

  gkm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_vld(q_vld), .q_item(q_item), .q_pop(q_pop));

  gkm_back u_back (
    .clk(clk), .rst_n(rst_n), .min_count(min_count_r),
    .q_vld(q_vld), .q_item(q_item), .q_pop(q_pop),
    .out_ch(out_ch), .stat(stat));

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.used <= USED_W'(MAX_GROUPS)) else $error("group count beyond table");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("result changed while stalled");
  a_no_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
    stat.draining |=> stat.used == $past(stat.used) || stat.used == '0)
    else $error("group count changed during drain");
`endif
endmodule
